/* design/bps_pkg.sv */
// Shared types, widths and constant tables for the binomial partial-sum block.
package bps_pkg;

	localparam int MAX_N   = 30;
	localparam int IN_W    = 5;
	localparam int NW      = $clog2(MAX_N + 1);
	localparam int CW      = MAX_N;
	localparam int PW      = CW + NW;
	localparam int TOTAL_W = MAX_N + 1;

	typedef logic [CW-1:0]      coef_t;
	typedef logic [NW-1:0]      idx_t;
	typedef logic [PW-1:0]      prod_t;
	typedef logic [TOTAL_W-1:0] total_t;
	typedef logic [2*CW-1:0]    wide_t;

	typedef coef_t inv_tbl_t [MAX_N+1];
	typedef idx_t  tz_tbl_t  [MAX_N+1];

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_MUL  = 4'b0010,
		ST_DIV  = 4'b0100,
		ST_FIN  = 4'b1000
	} state_t;

	typedef struct packed {
		logic   done;
		total_t total;
	} bps_res_t;

	// Inverse of the odd part of each divisor, modulo 2^CW.
	function automatic inv_tbl_t build_inv();
		inv_tbl_t t;
		coef_t    d;
		coef_t    x;
		for (int i = 0; i <= MAX_N; i++) begin
			d = (i == 0) ? coef_t'(1) : coef_t'(i);
			for (int b = 0; b < NW; b++) begin
				if (!d[0]) begin
					d = d >> 1;
				end
			end
			x = d;
			for (int j = 0; j < 7; j++) begin
				x = x * (coef_t'(2) - d * x);
			end
			t[i] = x;
		end
		return t;
	endfunction

	// Trailing zero count of each divisor.
	function automatic tz_tbl_t build_tz();
		tz_tbl_t t;
		coef_t   d;
		idx_t    z;
		for (int i = 0; i <= MAX_N; i++) begin
			d = (i == 0) ? coef_t'(1) : coef_t'(i);
			z = '0;
			for (int b = 0; b < NW; b++) begin
				if (!d[0]) begin
					d = d >> 1;
					z = z + idx_t'(1);
				end
			end
			t[i] = z;
		end
		return t;
	endfunction

	localparam inv_tbl_t INV_TBL = build_inv();
	localparam tz_tbl_t  TZ_TBL  = build_tz();

endpackage

/* design/bps_in_if.sv */
// Input channel: n and m with a valid/ready handshake.
interface bps_in_if import bps_pkg::*; ();
	logic            valid;
	logic            ready;
	logic [IN_W-1:0] n;
	logic [IN_W-1:0] m;

	modport source (output valid, output n, output m, input ready);
	modport sink   (input valid, input n, input m, output ready);
endinterface

/* design/bps_out_if.sv */
// Output channel: the partial sum with a valid/ready handshake.
interface bps_out_if import bps_pkg::*; ();
	logic   valid;
	logic   ready;
	total_t total;

	modport source (output valid, output total, input ready);
	modport sink   (input valid, input total, output ready);
endinterface

/* design/binomial_partial_sum_top.sv */
// Top level of the binomial partial-sum block: sequencer plus output register.
//
// Takes n and m and returns C(n,0)+...+C(n,m); m above n is clamped to n (giving 2^n) and
// n above MAX_N saturates. Each coefficient follows from the previous one as
// c*(n-k)/(k+1), the exact division done by a shift and a multiply with a tabled inverse,
// so one shared multiplier serves both the product step and the division step of each
// term. An accepted item passes through both steps for each of its min(m,n) terms and then
// a finish state; the input is not ready again until the result is written into the output
// register, which may still be waiting to be taken while the next item is accepted.
module binomial_partial_sum_top import bps_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	bps_in_if.sink   in_ch,
	bps_out_if.source out_ch
);
	bps_res_t res;
	logic     out_valid_q;
	total_t   total_q;
	logic     out_free;

	assign out_free = !out_valid_q || out_ch.ready;

	bps_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (in_ch),
		.out_free (out_free),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res.done) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.done) begin
			total_q <= res.total;
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.total = total_q;

endmodule

/* design/bps_mul.sv */
// Shared multiplier used for both the running product and the exact division.
module bps_mul import bps_pkg::*; (
	input  coef_t a,
	input  coef_t b,
	output wide_t p
);
	assign p = wide_t'(a) * wide_t'(b);
endmodule

/* design/bps_ctrl.sv */
// Sequencer and datapath: builds each coefficient and accumulates the sum.
module bps_ctrl import bps_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	bps_in_if.sink        in_ch,
	input  logic          out_free,
	output bps_res_t      res
);
	state_t state_q;
	idx_t   n_q;
	idx_t   m_q;
	idx_t   k_q;
	coef_t  c_q;
	prod_t  prod_q;
	total_t sum_q;

	idx_t   n_c;
	idx_t   m_c;
	idx_t   div_d;
	coef_t  shifted;
	coef_t  mul_a;
	coef_t  mul_b;
	wide_t  mul_p;
	logic   accept;

	assign in_ch.ready = (state_q == ST_IDLE);
	assign accept      = in_ch.valid && in_ch.ready;

	always_comb begin
		n_c = (int'(in_ch.n) > MAX_N) ? idx_t'(MAX_N) : idx_t'(in_ch.n);
		m_c = (int'(in_ch.m) > int'(n_c)) ? n_c : idx_t'(in_ch.m);
	end

	assign div_d   = k_q + idx_t'(1);
	assign shifted = coef_t'(prod_q >> TZ_TBL[div_d]);

	always_comb begin
		case (state_q)
			ST_DIV: begin
				mul_a = shifted;
				mul_b = INV_TBL[div_d];
			end
			default: begin
				mul_a = c_q;
				mul_b = coef_t'(n_q - k_q);
			end
		endcase
	end

	bps_mul u_mul (
		.a (mul_a),
		.b (mul_b),
		.p (mul_p)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q     <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						k_q     <= '0;
						state_q <= (m_c == '0) ? ST_FIN : ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					k_q     <= div_d;
					state_q <= (div_d == m_q) ? ST_FIN : ST_MUL;
				end
				ST_FIN: begin
					// hold until the output register has room
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			n_q   <= n_c;
			m_q   <= m_c;
			c_q   <= coef_t'(1);
			sum_q <= total_t'(1);
		end
		if (state_q == ST_MUL) begin
			prod_q <= mul_p[PW-1:0];
		end
		if (state_q == ST_DIV) begin
			c_q   <= mul_p[CW-1:0];
			sum_q <= sum_q + total_t'(mul_p[CW-1:0]);
		end
	end

	assign res.done  = (state_q == ST_FIN) && out_free;
	assign res.total = sum_q;

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q != ST_IDLE))
		else $error("sequencer stayed idle after taking an item");

	a_term_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (k_q < m_q) && (m_q <= n_q))
		else $error("term index beyond clamped limit");

	a_done_returns_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res.done |=> (state_q == ST_IDLE))
		else $error("sequencer did not return to idle after delivering");

	a_mul_then_div: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL) |=> (state_q == ST_DIV))
		else $error("product step not followed by division step");

endmodule
